// ===== design/cfl_pkg.sv =====
// ----------------------------------------------------------------------------
// cfl_pkg
// Shared sizes, codes and structs for the credit flow limiter.
// ----------------------------------------------------------------------------
package cfl_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DESC_WIDTH  = 32;

  localparam int DESC_FW   = 32;   // descriptor field width on the ports
  localparam int CREDIT_W  = 16;
  localparam int QCOUNT_W  = 5;
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W     = (CNT_W > QCOUNT_W) ? CNT_W : QCOUNT_W;
  localparam int STORE_W   = (DESC_WIDTH < DESC_FW) ? DESC_WIDTH : DESC_FW;

  typedef enum logic [2:0] {
    OUT_CTRL_PASS = 3'd0,
    OUT_ADMITTED  = 3'd1,
    OUT_QUEUED    = 3'd2,
    OUT_DROP_NEW  = 3'd3,
    OUT_DROP_OLD  = 3'd4,
    OUT_FIN_REL   = 3'd5,
    OUT_FIN_ONLY  = 3'd6
  } outcome_t;

  typedef enum logic [1:0] {
    REG_CREDIT_LIMIT = 2'd0,
    REG_QUEUE_CAP    = 2'd1,
    REG_DROP_POLICY  = 2'd2
  } cfg_reg_t;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam logic POLICY_DROP_NEW = 1'b1;

  typedef struct packed {
    logic [CREDIT_W-1:0] credit_limit;
    logic [QCOUNT_W-1:0] wait_cap;
    logic                drop_policy;
  } cfl_cfg_t;

  typedef struct packed {
    logic [CREDIT_W-1:0] in_flight;
    logic [CNT_W-1:0]    fill;
    logic [PTR_W-1:0]    head;
  } cfl_state_t;

  typedef struct packed {
    cfl_state_t          nxt;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [STORE_W-1:0]  wr_data;
    logic                emit;
    logic [DESC_FW-1:0]  desc;
    outcome_t            outcome;
  } cfl_step_t;

  // head + n modulo the queue depth; head < depth, n <= depth
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] head,
                                               input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(n);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// ===== design/cfl_wait_ram.sv =====
// ----------------------------------------------------------------------------
// cfl_wait_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cfl_wait_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/cfl_step.sv =====
// ----------------------------------------------------------------------------
// cfl_step
// Decision logic for one word: credit check, queue push/pop, drop policy.
// ----------------------------------------------------------------------------
module cfl_step
  import cfl_pkg::*;
(
  input  logic               op,
  input  logic               is_control,
  input  logic [DESC_FW-1:0] descriptor,
  input  cfl_cfg_t           cfg,
  input  cfl_state_t         cur,
  input  logic [STORE_W-1:0] head_data,
  output cfl_step_t          res
);

  logic [CMP_W-1:0]    cap_q;
  logic [CMP_W-1:0]    cap;
  logic [CMP_W-1:0]    fill_c;
  logic [CREDIT_W-1:0] dec;
  logic [STORE_W-1:0]  desc_s;
  logic [PTR_W-1:0]    tail;
  logic [PTR_W-1:0]    head_inc;

  always_comb begin
    cap_q    = CMP_W'(cfg.wait_cap);
    cap      = (cap_q > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : cap_q;
    fill_c   = CMP_W'(cur.fill);
    dec      = (cur.in_flight == '0) ? '0 : cur.in_flight - CREDIT_W'(1);
    desc_s   = descriptor[STORE_W-1:0];
    tail     = ptr_add(cur.head, cur.fill);
    head_inc = ptr_add(cur.head, CNT_W'(1));

    res         = '0;
    res.nxt     = cur;
    res.wr_addr = tail;
    res.wr_data = desc_s;
    res.outcome = OUT_FIN_ONLY;

    if (op == OP_FINISH) begin
      if ((cur.fill != '0) && (dec < cfg.credit_limit)) begin
        res.nxt.head      = head_inc;
        res.nxt.fill      = cur.fill - CNT_W'(1);
        res.nxt.in_flight = dec + CREDIT_W'(1);
        res.emit          = 1'b1;
        res.desc          = DESC_FW'(head_data);
        res.outcome       = OUT_FIN_REL;
      end else begin
        res.nxt.in_flight = dec;
        res.outcome       = OUT_FIN_ONLY;
      end
    end else if (is_control) begin
      res.emit    = 1'b1;
      res.desc    = DESC_FW'(desc_s);
      res.outcome = OUT_CTRL_PASS;
    end else if (cur.in_flight < cfg.credit_limit) begin
      res.nxt.in_flight = cur.in_flight + CREDIT_W'(1);
      res.emit          = 1'b1;
      res.desc          = DESC_FW'(desc_s);
      res.outcome       = OUT_ADMITTED;
    end else if (cap == '0) begin
      res.outcome = OUT_DROP_NEW;
    end else if (fill_c >= cap) begin
      if (cfg.drop_policy == POLICY_DROP_NEW) begin
        res.outcome = OUT_DROP_NEW;
      end else begin
        // oldest leaves, new word lands in the slot just past the old tail
        res.nxt.head = head_inc;
        res.wr_en    = 1'b1;
        res.outcome  = OUT_DROP_OLD;
      end
    end else begin
      res.nxt.fill = cur.fill + CNT_W'(1);
      res.wr_en    = 1'b1;
      res.outcome  = OUT_QUEUED;
    end
  end

endmodule

// ===== design/credit_flow_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// credit_flow_limiter_unit
// Credit-based admission limiter with a drop queue held in a RAM.
// ----------------------------------------------------------------------------
//
//  port group | dir | payload
//  -----------+-----+----------------------------------------------------------
//  in_*       | in  | tdata: descriptor; tuser: op, is_control
//  out_*      | out | tdata: out_descriptor, in_flight_now, queue_count;
//             |     | tuser: emit_valid, outcome
//  cfg_*      | in  | index 0 credit limit, 1 wait slots, 2 drop policy
//
// Per word: the accept cycle presents the queue head
// address to the RAM, the next cycle uses the registered head entry, updates
// counters, writes the RAM and loads the output register.
// No new word is taken before the last one is done, as the RAM read is registered.
// in_tready drops while a word is in work or the output register is full and
// not being drained this cycle. rst_n is synchronous: counters and config go
// to their reset values, the RAM contents are not cleared (only written
// entries are ever read). cfg_ready is always high.
// ----------------------------------------------------------------------------
module credit_flow_limiter_unit
  import cfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] descriptor
  input  logic [1:0]  in_tuser,    // [0] op, [1] is_control

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [31:0] out_descriptor, [47:32] in_flight_now,
                                   // [52:48] queue_count, [55:53] zero
  output logic [3:0]  out_tuser,   // [0] emit_valid, [3:1] outcome

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } fsm_t;

  fsm_t       state_r, state_nxt;
  cfl_cfg_t   cfg_r;
  cfl_state_t cur_r;

  // captured input word
  logic               op_r;
  logic               ctl_r;
  logic [DESC_FW-1:0] desc_r;

  // output register
  logic                out_valid_r;
  logic                emit_r;
  logic [DESC_FW-1:0]  odesc_r;
  outcome_t            outcome_r;
  logic [CREDIT_W-1:0] in_flight_o_r;
  logic [QCOUNT_W-1:0] qcount_o_r;

  logic [STORE_W-1:0] head_data;
  cfl_step_t          step;
  logic               in_acc;
  logic               out_acc;

  assign cfg_ready = 1'b1;
  assign out_acc   = out_tvalid & out_tready;
  // accept only when the output slot will be free by the time it is loaded
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid & in_tready;

  // queue storage; read port always tracks the head
  cfl_wait_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (PTR_W),
    .DATA_W (STORE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (step.wr_en && (state_r == ST_EXEC)),
    .wr_addr (step.wr_addr),
    .wr_data (step.wr_data),
    .rd_addr (cur_r.head),
    .rd_data (head_data)
  );

  cfl_step u_step (
    .op         (op_r),
    .is_control (ctl_r),
    .descriptor (desc_r),
    .cfg        (cfg_r),
    .cur        (cur_r),
    .head_data  (head_data),
    .res        (step)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r                    <= ST_IDLE;
      cfg_r.credit_limit         <= CREDIT_W'(1);
      cfg_r.wait_cap             <= QCOUNT_W'(1);
      cfg_r.drop_policy          <= 1'b0;
      cur_r                      <= '0;
      out_valid_r                <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CREDIT_LIMIT: cfg_r.credit_limit <= cfg_data;
          REG_QUEUE_CAP:    cfg_r.wait_cap     <= cfg_data[QCOUNT_W-1:0];
          REG_DROP_POLICY:  cfg_r.drop_policy  <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (state_r == ST_EXEC) begin
        cur_r       <= step.nxt;
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_tuser[0];
      ctl_r  <= in_tuser[1];
      desc_r <= in_tdata;
    end
    if (state_r == ST_EXEC) begin
      emit_r        <= step.emit;
      odesc_r       <= step.desc;
      outcome_r     <= step.outcome;
      in_flight_o_r <= step.nxt.in_flight;
      qcount_o_r    <= QCOUNT_W'(step.nxt.fill);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, qcount_o_r, in_flight_o_r, odesc_r};
  assign out_tuser  = {outcome_r, emit_r};

endmodule
